// ----- rtl/vrmp_pkg.sv -----
package vrmp_pkg;

   localparam int VIEWERS_DEFAULT = 4;

   localparam int INDEX_W = 3;
   localparam int FRAME_W = 32;
   localparam int POS_W   = 20;
   localparam int VEC_W   = 16;
   localparam int JL_W    = 12;
   localparam int PHASE_W = 24;
   localparam int OUT_W   = 14;

   localparam logic [JL_W-1:0] JUMP_LIMIT_RESET = 12'd200;

   localparam int DELTA_W = POS_W + 1;
   localparam int DIFF_W  = VEC_W + 1;
   localparam int MA_W    = DELTA_W;
   localparam int MB_W    = 2 * VEC_W + 1;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int ACC_W   = PROD_W + 3;
   localparam int D2_W    = 2 * DELTA_W;
   localparam int LIM2_W  = 2 * JL_W;
   localparam int ALONG_SHIFT = VEC_W - 2;

   localparam int QSHIFT      = 13;
   localparam int M_W         = ACC_W - QSHIFT;
   localparam int DVD_W       = 48;
   localparam int RADIX_BITS  = 4;
   localparam int DIGITS      = DVD_W / RADIX_BITS;
   localparam int REM_W       = 5;
   localparam logic [REM_W:0] DIV_CONST = 6'd25;
   localparam logic [DVD_W-1:0] DIV_OFFSET = DVD_W'(DIV_CONST) << (M_W - 1);

   localparam logic [3:0] OP_LIM = 4'd0;
   localparam logic [3:0] OP_DXX = 4'd1;
   localparam logic [3:0] OP_DYY = 4'd2;
   localparam logic [3:0] OP_DZZ = 4'd3;
   localparam logic [3:0] OP_RX0 = 4'd4;
   localparam logic [3:0] OP_RX1 = 4'd5;
   localparam logic [3:0] OP_RY0 = 4'd6;
   localparam logic [3:0] OP_RY1 = 4'd7;
   localparam logic [3:0] OP_RZ0 = 4'd8;
   localparam logic [3:0] OP_RZ1 = 4'd9;
   localparam logic [3:0] OP_AC0 = 4'd10;
   localparam logic [3:0] OP_AC1 = 4'd11;
   localparam logic [3:0] OP_AC2 = 4'd12;
   localparam logic [3:0] OP_AL0 = 4'd13;
   localparam logic [3:0] OP_AL1 = 4'd14;
   localparam logic [3:0] OP_AL2 = 4'd15;
   localparam int MUL_OPS = 16;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage

// ----- rtl/view_relative_motion_phase_top.sv -----
// View-relative motion phase: one camera sample per viewer per frame in, one
// result out. Each viewer keeps two 24-bit phase accumulators that advance
// with the camera move projected onto the right and along directions.
//
// req_* carries the sample; it is taken when req_valid is high and req_stall
// is low. rsp_* carries the result under rsp_valid / rsp_stall. csr_* writes
// jump_limit; csr_ready is always high, write only while the block is idle.
//
// Flow: an invalid viewer or a repeated frame goes straight to the finish
// state and from there to the result register. A new frame runs through the
// shared 21x33 multiplier, then, when the viewer was seen before and the move
// is under 16 times the jump limit, two divisions by 25 on the same
// 4-bit-per-cycle divider. One sample is in work at a time; req_stall is high
// from accept until the result is handed to the output register.
// A held result does not block the next accept; the finished result of that
// sample waits until the output register is free.
//
// Reset clears all viewer state (positions, frames, phases, seen flags),
// restores jump_limit to 200 and drops any pending result.
module view_relative_motion_phase_top #(
   parameter int VIEWERS = vrmp_pkg::VIEWERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vrmp_pkg::INDEX_W-1:0]        req_viewer_index,
   input  logic                                req_viewer_present,
   input  logic [vrmp_pkg::FRAME_W-1:0]        req_frame_number,
   input  logic signed [vrmp_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [vrmp_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [vrmp_pkg::POS_W-1:0]   req_pos_z,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_look_x,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_look_y,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_look_z,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_up_x,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_up_y,
   input  logic signed [vrmp_pkg::VEC_W-1:0]   req_up_z,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_valid,
   output logic [vrmp_pkg::OUT_W-1:0]          rsp_turn_s,
   output logic [vrmp_pkg::OUT_W-1:0]          rsp_turn_t,
   output logic [vrmp_pkg::OUT_W-1:0]          rsp_scroll_s,
   output logic [vrmp_pkg::OUT_W-1:0]          rsp_scroll_t,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vrmp_pkg::JL_W-1:0]           csr_jump_limit
);
   import vrmp_pkg::*;

   localparam int IDX_W = (VIEWERS > 1) ? $clog2(VIEWERS) : 1;

   state_type                  state_ff, state_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [3:0]                 dcnt_ff, dcnt_in;
   logic                       sel_ff, sel_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [JL_W-1:0]            jump_limit_ff, jump_limit_in;

   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       valid_ff, valid_in;
   logic                       upd_ff, upd_in;
   logic                       seen_ff, seen_in;
   logic [FRAME_W-1:0]         frame_ff, frame_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic signed [VEC_W-1:0]    lx_ff, lx_in, ly_ff, ly_in, lz_ff, lz_in;
   logic signed [VEC_W-1:0]    ux_ff, ux_in, uy_ff, uy_in, uz_ff, uz_in;
   logic signed [DELTA_W-1:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [LIM2_W-1:0]          lim2_ff, lim2_in;
   logic [D2_W-1:0]            d2_ff, d2_in;
   logic signed [MB_W-1:0]     rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic signed [ACC_W-1:0]    across_ff, across_in, along_ff, along_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [PHASE_W-1:0]         quo_ff, quo_in;
   logic [PHASE_W-1:0]         across_ph_ff, across_ph_in, along_ph_ff, along_ph_in;
   logic                       out_rv_ff, out_rv_in;
   logic [OUT_W-1:0]           out_ts_ff, out_ts_in, out_tt_ff, out_tt_in;
   logic [OUT_W-1:0]           out_ss_ff, out_ss_in, out_st_ff, out_st_in;

   logic signed [POS_W-1:0]    last_x_ff [VIEWERS];
   logic signed [POS_W-1:0]    last_y_ff [VIEWERS];
   logic signed [POS_W-1:0]    last_z_ff [VIEWERS];
   logic [PHASE_W-1:0]         acr_arr_ff [VIEWERS];
   logic [PHASE_W-1:0]         alg_arr_ff [VIEWERS];
   logic [FRAME_W-1:0]         frame_arr_ff [VIEWERS];
   logic [VIEWERS-1:0]         seen_arr_ff;

   logic                       req_xfer;
   logic                       fin_go;
   logic [IDX_W-1:0]           req_idx;
   logic                       req_ok;
   logic [3:0]                 op_iss, op_acc;
   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [ACC_W-1:0]    acc_sum;
   logic                       acc_first, acc_last;
   logic                       accrue;
   logic [M_W-1:0]             div_m;
   logic [DVD_W-1:0]           dvd_load;
   logic [REM_W:0]             rem_t;
   logic [PHASE_W-1:0]         quo_t;
   logic [PHASE_W-1:0]         ph_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign fin_go    = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign req_idx   = req_viewer_index[IDX_W-1:0];
   assign req_ok    = req_viewer_present &&
                      ({1'b0, req_viewer_index} < (INDEX_W + 1)'(VIEWERS));
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_valid = out_rv_ff;
   assign rsp_turn_s       = out_ts_ff;
   assign rsp_turn_t       = out_tt_ff;
   assign rsp_scroll_s     = out_ss_ff;
   assign rsp_scroll_t     = out_st_ff;

   // multiplier operand select, one step per cycle
   assign op_iss = cnt_ff[3:0];
   assign op_acc = 4'(cnt_ff - 5'd1);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_iss)
         OP_LIM: begin
            mul_a = MA_W'(jump_limit_ff);
            mul_b = MB_W'(jump_limit_ff);
         end
         OP_DXX: begin mul_a = dx_ff; mul_b = MB_W'(dx_ff); end
         OP_DYY: begin mul_a = dy_ff; mul_b = MB_W'(dy_ff); end
         OP_DZZ: begin mul_a = dz_ff; mul_b = MB_W'(dz_ff); end
         OP_RX0: begin mul_a = MA_W'(ly_ff); mul_b = MB_W'(uz_ff); end
         OP_RX1: begin mul_a = -MA_W'(lz_ff); mul_b = MB_W'(uy_ff); end
         OP_RY0: begin mul_a = MA_W'(lz_ff); mul_b = MB_W'(ux_ff); end
         OP_RY1: begin mul_a = -MA_W'(lx_ff); mul_b = MB_W'(uz_ff); end
         OP_RZ0: begin mul_a = MA_W'(lx_ff); mul_b = MB_W'(uy_ff); end
         OP_RZ1: begin mul_a = -MA_W'(ly_ff); mul_b = MB_W'(ux_ff); end
         OP_AC0: begin mul_a = dx_ff; mul_b = rx_ff; end
         OP_AC1: begin mul_a = dy_ff; mul_b = ry_ff; end
         OP_AC2: begin mul_a = dz_ff; mul_b = rz_ff; end
         OP_AL0: begin
            mul_a = dx_ff;
            mul_b = MB_W'(DIFF_W'(lx_ff) - DIFF_W'(ux_ff));
         end
         OP_AL1: begin
            mul_a = dy_ff;
            mul_b = MB_W'(DIFF_W'(ly_ff) - DIFF_W'(uy_ff));
         end
         OP_AL2: begin
            mul_a = dz_ff;
            mul_b = MB_W'(DIFF_W'(lz_ff) - DIFF_W'(uz_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      acc_first = 1'b0;
      acc_last  = 1'b0;
      case (op_acc)
         OP_LIM: begin acc_first = 1'b1; acc_last = 1'b1; end
         OP_DXX, OP_RX0, OP_RY0, OP_RZ0, OP_AC0, OP_AL0: acc_first = 1'b1;
         OP_DZZ, OP_RX1, OP_RY1, OP_RZ1, OP_AC2, OP_AL2: acc_last = 1'b1;
         default: begin
            acc_first = 1'b0;
            acc_last  = 1'b0;
         end
      endcase
   end

   assign acc_sum = (acc_first ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
   assign accrue  = seen_ff && (d2_ff < D2_W'({lim2_ff, 8'h00}));

   // divide by 25: offset keeps the dividend positive, low quotient bits unchanged
   assign div_m    = sel_ff ? along_ff[ACC_W-1:QSHIFT] : across_ff[ACC_W-1:QSHIFT];
   assign dvd_load = DVD_W'(signed'(div_m)) + DIV_OFFSET;

   always_comb begin
      logic [REM_W:0] tmp;
      rem_t = {1'b0, rem_ff};
      quo_t = quo_ff;
      for (int k = 0; k < RADIX_BITS; k++) begin
         tmp = {rem_t[REM_W-1:0], dvd_ff[DVD_W-1-k]};
         if (tmp >= DIV_CONST) begin
            tmp   = tmp - DIV_CONST;
            quo_t = {quo_t[PHASE_W-2:0], 1'b1};
         end else begin
            quo_t = {quo_t[PHASE_W-2:0], 1'b0};
         end
         rem_t = tmp;
      end
   end

   assign ph_sum = (sel_ff ? along_ph_ff : across_ph_ff) + quo_t;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      dcnt_in       = dcnt_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      jump_limit_in = jump_limit_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      upd_in        = upd_ff;
      seen_in       = seen_ff;
      frame_in      = frame_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pos_z_in      = pos_z_ff;
      lx_in         = lx_ff;
      ly_in         = ly_ff;
      lz_in         = lz_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      uz_in         = uz_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      prod_in       = mul_a * mul_b;
      acc_in        = acc_ff;
      lim2_in       = lim2_ff;
      d2_in         = d2_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rz_in         = rz_ff;
      across_in     = across_ff;
      along_in      = along_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      across_ph_in  = across_ph_ff;
      along_ph_in   = along_ph_ff;
      out_rv_in     = out_rv_ff;
      out_ts_in     = out_ts_ff;
      out_tt_in     = out_tt_ff;
      out_ss_in     = out_ss_ff;
      out_st_in     = out_st_ff;

      if (csr_valid && csr_ready) begin
         jump_limit_in = csr_jump_limit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in       = req_idx;
               valid_in     = req_ok;
               upd_in       = req_ok && (frame_arr_ff[req_idx] != req_frame_number);
               seen_in      = seen_arr_ff[req_idx];
               frame_in     = req_frame_number;
               pos_x_in     = req_pos_x;
               pos_y_in     = req_pos_y;
               pos_z_in     = req_pos_z;
               lx_in        = req_look_x;
               ly_in        = req_look_y;
               lz_in        = req_look_z;
               ux_in        = req_up_x;
               uy_in        = req_up_y;
               uz_in        = req_up_z;
               dx_in        = DELTA_W'(req_pos_x) - DELTA_W'(last_x_ff[req_idx]);
               dy_in        = DELTA_W'(req_pos_y) - DELTA_W'(last_y_ff[req_idx]);
               dz_in        = DELTA_W'(req_pos_z) - DELTA_W'(last_z_ff[req_idx]);
               across_ph_in = acr_arr_ff[req_idx];
               along_ph_in  = alg_arr_ff[req_idx];
               cnt_in       = '0;
               state_in     = (req_ok && (frame_arr_ff[req_idx] != req_frame_number))
                              ? ST_MUL : ST_FIN;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               acc_in = acc_sum;
               if (acc_last) begin
                  case (op_acc)
                     OP_LIM: lim2_in   = acc_sum[LIM2_W-1:0];
                     OP_DZZ: d2_in     = acc_sum[D2_W-1:0];
                     OP_RX1: rx_in     = acc_sum[MB_W-1:0];
                     OP_RY1: ry_in     = acc_sum[MB_W-1:0];
                     OP_RZ1: rz_in     = acc_sum[MB_W-1:0];
                     OP_AC2: across_in = acc_sum;
                     OP_AL2: along_in  = {acc_sum[ACC_W-1-ALONG_SHIFT:0],
                                          ALONG_SHIFT'(0)};
                     default: acc_in   = acc_sum;
                  endcase
               end
            end
            if (cnt_ff == 5'(MUL_OPS)) begin
               sel_in   = 1'b0;
               state_in = accrue ? ST_LOAD : ST_FIN;
            end
         end
         ST_LOAD: begin
            dvd_in   = dvd_load;
            rem_in   = '0;
            quo_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dvd_in  = dvd_ff << RADIX_BITS;
            rem_in  = rem_t[REM_W-1:0];
            quo_in  = quo_t;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(DIGITS - 1)) begin
               if (sel_ff) begin
                  along_ph_in = ph_sum;
                  state_in    = ST_FIN;
               end else begin
                  across_ph_in = ph_sum;
                  sel_in       = 1'b1;
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               out_rv_in    = valid_ff;
               out_ts_in    = valid_ff ? across_ph_ff[PHASE_W-1 -: OUT_W] : '0;
               out_tt_in    = valid_ff ? along_ph_ff[PHASE_W-1 -: OUT_W] : '0;
               out_ss_in    = valid_ff ? across_ph_ff[PHASE_W-2 -: OUT_W] : '0;
               out_st_in    = valid_ff ? along_ph_ff[PHASE_W-2 -: OUT_W] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         dcnt_ff       <= '0;
         sel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         jump_limit_ff <= JUMP_LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         dcnt_ff       <= dcnt_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         jump_limit_ff <= jump_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      valid_ff     <= valid_in;
      upd_ff       <= upd_in;
      seen_ff      <= seen_in;
      frame_ff     <= frame_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      pos_z_ff     <= pos_z_in;
      lx_ff        <= lx_in;
      ly_ff        <= ly_in;
      lz_ff        <= lz_in;
      ux_ff        <= ux_in;
      uy_ff        <= uy_in;
      uz_ff        <= uz_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      lim2_ff      <= lim2_in;
      d2_ff        <= d2_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rz_ff        <= rz_in;
      across_ff    <= across_in;
      along_ff     <= along_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      across_ph_ff <= across_ph_in;
      along_ph_ff  <= along_ph_in;
      out_rv_ff    <= out_rv_in;
      out_ts_ff    <= out_ts_in;
      out_tt_ff    <= out_tt_in;
      out_ss_ff    <= out_ss_in;
      out_st_ff    <= out_st_in;
   end

   // per-viewer state, written back when the sample is handed off
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_arr_ff <= '0;
         for (int i = 0; i < VIEWERS; i++) begin
            last_x_ff[i]    <= '0;
            last_y_ff[i]    <= '0;
            last_z_ff[i]    <= '0;
            acr_arr_ff[i]   <= '0;
            alg_arr_ff[i]   <= '0;
            frame_arr_ff[i] <= '0;
         end
      end else if (fin_go && upd_ff) begin
         seen_arr_ff[idx_ff]  <= 1'b1;
         last_x_ff[idx_ff]    <= pos_x_ff;
         last_y_ff[idx_ff]    <= pos_y_ff;
         last_z_ff[idx_ff]    <= pos_z_ff;
         acr_arr_ff[idx_ff]   <= across_ph_ff;
         alg_arr_ff[idx_ff]   <= along_ph_ff;
         frame_arr_ff[idx_ff] <= frame_ff;
      end
   end

endmodule

// ----- rtl/vrmp_checker.sv -----
module vrmp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_result_valid,
   input logic [vrmp_pkg::OUT_W-1:0]    rsp_turn_s,
   input logic [vrmp_pkg::OUT_W-1:0]    rsp_turn_t,
   input logic [vrmp_pkg::OUT_W-1:0]    rsp_scroll_s,
   input logic [vrmp_pkg::OUT_W-1:0]    rsp_scroll_t
);
   import vrmp_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_turn_s) &&
      $stable(rsp_turn_t) && $stable(rsp_scroll_s) && $stable(rsp_scroll_t) &&
      $stable(rsp_result_valid))
      else $error("stalled result changed");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous sample in work");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_turn_s == '0 && rsp_turn_t == '0 &&
      rsp_scroll_s == '0 && rsp_scroll_t == '0)
      else $error("invalid viewer result not zero");

   a_scroll_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scroll_s[OUT_W-1:1] == rsp_turn_s[OUT_W-2:0] &&
      rsp_scroll_t[OUT_W-1:1] == rsp_turn_t[OUT_W-2:0])
      else $error("scroll shift does not match turn shift");

endmodule

bind view_relative_motion_phase_top vrmp_checker u_vrmp_checker (.*);

// ----- sim/view_relative_motion_phase_top_tb.sv -----
module view_relative_motion_phase_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vrmp_pkg::*;

   localparam int VIEWERS = VIEWERS_DEFAULT;
   localparam longint TURN_DIV = 204800;
   localparam int ITEMS_PER_SETTING = 130;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [INDEX_W-1:0] viewer_index;
      logic               viewer_present;
      logic [FRAME_W-1:0] frame_number;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [VEC_W-1:0]   look_x;
      logic [VEC_W-1:0]   look_y;
      logic [VEC_W-1:0]   look_z;
      logic [VEC_W-1:0]   up_x;
      logic [VEC_W-1:0]   up_y;
      logic [VEC_W-1:0]   up_z;
   } sample_t;

   typedef struct packed {
      logic             result_valid;
      logic [OUT_W-1:0] turn_s;
      logic [OUT_W-1:0] turn_t;
      logic [OUT_W-1:0] scroll_s;
      logic [OUT_W-1:0] scroll_t;
   } shift_result_t;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_HEAVY
   } stall_mode_t;

   class phase_scoreboard;
      logic [JL_W-1:0]           jump_limit;
      logic signed [POS_W-1:0]   last_x [VIEWERS];
      logic signed [POS_W-1:0]   last_y [VIEWERS];
      logic signed [POS_W-1:0]   last_z [VIEWERS];
      logic [PHASE_W-1:0]        across [VIEWERS];
      logic [PHASE_W-1:0]        along [VIEWERS];
      logic [FRAME_W-1:0]        last_frame [VIEWERS];
      bit                        seen [VIEWERS];
      shift_result_t             expected_q [$];
      int                        fails;

      function new();
         jump_limit = JUMP_LIMIT_RESET;
         fails = 0;
         for (int i = 0; i < VIEWERS; i++) begin
            last_x[i] = '0;
            last_y[i] = '0;
            last_z[i] = '0;
            across[i] = '0;
            along[i] = '0;
            last_frame[i] = '0;
            seen[i] = 1'b0;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [PHASE_W-1:0] phase_step(longint q32);
         longint q;
         q = q32 / TURN_DIV;
         if ((q32 % TURN_DIV) != 0 && q32 < 0)
            q = q - 1;
         return q[PHASE_W-1:0];
      endfunction

      function void note_sample(sample_t s);
         shift_result_t r;
         int v;
         longint dx, dy, dz, lim, lx, ly, lz, ux, uy, uz;
         r = '0;
         if (s.viewer_present && s.viewer_index < VIEWERS) begin
            v = int'(s.viewer_index);
            if (last_frame[v] != s.frame_number) begin
               dx = longint'($signed(s.pos_x)) - longint'(last_x[v]);
               dy = longint'($signed(s.pos_y)) - longint'(last_y[v]);
               dz = longint'($signed(s.pos_z)) - longint'(last_z[v]);
               lim = longint'(jump_limit) * 16;
               if (seen[v] && dx * dx + dy * dy + dz * dz < lim * lim) begin
                  lx = longint'($signed(s.look_x));
                  ly = longint'($signed(s.look_y));
                  lz = longint'($signed(s.look_z));
                  ux = longint'($signed(s.up_x));
                  uy = longint'($signed(s.up_y));
                  uz = longint'($signed(s.up_z));
                  across[v] += phase_step((ly * uz - lz * uy) * dx + (lz * ux - lx * uz) * dy
                                          + (lx * uy - ly * ux) * dz);
                  along[v] += phase_step((dx * (lx - ux) + dy * (ly - uy) + dz * (lz - uz))
                                         * 16384);
               end
               last_x[v] = s.pos_x;
               last_y[v] = s.pos_y;
               last_z[v] = s.pos_z;
               last_frame[v] = s.frame_number;
               seen[v] = 1'b1;
            end
            r.result_valid = 1'b1;
            r.turn_s = across[v][PHASE_W-1 -: OUT_W];
            r.turn_t = along[v][PHASE_W-1 -: OUT_W];
            r.scroll_s = across[v][PHASE_W-2 -: OUT_W];
            r.scroll_t = along[v][PHASE_W-2 -: OUT_W];
         end
         expected_q.push_back(r);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
         end
      endfunction

      function void check_result(shift_result_t got);
         shift_result_t want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no sample pending");
            fails++;
            return;
         end
         want = expected_q.pop_front();
         check_field("result_valid", want.result_valid, got.result_valid);
         check_field("turn_s", want.turn_s, got.turn_s);
         check_field("turn_t", want.turn_t, got.turn_t);
         check_field("scroll_s", want.scroll_s, got.scroll_s);
         check_field("scroll_t", want.scroll_t, got.scroll_t);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [INDEX_W-1:0] req_viewer_index = '0;
   logic               req_viewer_present = 1'b0;
   logic [FRAME_W-1:0] req_frame_number = '0;
   logic [POS_W-1:0]   req_pos_x = '0;
   logic [POS_W-1:0]   req_pos_y = '0;
   logic [POS_W-1:0]   req_pos_z = '0;
   logic [VEC_W-1:0]   req_look_x = '0;
   logic [VEC_W-1:0]   req_look_y = '0;
   logic [VEC_W-1:0]   req_look_z = '0;
   logic [VEC_W-1:0]   req_up_x = '0;
   logic [VEC_W-1:0]   req_up_y = '0;
   logic [VEC_W-1:0]   req_up_z = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_valid;
   logic [OUT_W-1:0]   rsp_turn_s;
   logic [OUT_W-1:0]   rsp_turn_t;
   logic [OUT_W-1:0]   rsp_scroll_s;
   logic [OUT_W-1:0]   rsp_scroll_t;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [JL_W-1:0]    csr_jump_limit = JUMP_LIMIT_RESET;

   phase_scoreboard board = new();
   int jump_setting = 200;
   logic [FRAME_W-1:0] walk_frame [VIEWERS];
   int walk_x [VIEWERS];
   int walk_y [VIEWERS];
   int walk_z [VIEWERS];
   stall_mode_t stall_mode = STALL_NONE;
   int stall_left = 0;
   int cycles = 0;

   view_relative_motion_phase_top #(
      .VIEWERS(VIEWERS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_viewer_index(req_viewer_index),
      .req_viewer_present(req_viewer_present),
      .req_frame_number(req_frame_number),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_look_x(req_look_x),
      .req_look_y(req_look_y),
      .req_look_z(req_look_z),
      .req_up_x(req_up_x),
      .req_up_y(req_up_y),
      .req_up_z(req_up_z),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_valid(rsp_result_valid),
      .rsp_turn_s(rsp_turn_s),
      .rsp_turn_t(rsp_turn_t),
      .rsp_scroll_s(rsp_scroll_s),
      .rsp_scroll_t(rsp_scroll_t),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_jump_limit(csr_jump_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("view_relative_motion_phase_top_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_result_valid, rsp_turn_s, rsp_turn_t,
                             rsp_scroll_s, rsp_scroll_t});
      if (stall_left == 0) begin
         stall_mode <= stall_mode_t'($urandom_range(0, 2));
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic sample_t make_sample(int idx, int present, logic [FRAME_W-1:0] frame,
                                           int px, int py, int pz, int lx, int ly, int lz,
                                           int ux, int uy, int uz);
      sample_t s;
      s.viewer_index = idx;
      s.viewer_present = present;
      s.frame_number = frame;
      s.pos_x = px;
      s.pos_y = py;
      s.pos_z = pz;
      s.look_x = lx;
      s.look_y = ly;
      s.look_z = lz;
      s.up_x = ux;
      s.up_y = uy;
      s.up_z = uz;
      return s;
   endfunction

   function automatic int rand_component(bit wide);
      if (wide)
         return $urandom_range(0, 65535);
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   function automatic sample_t next_sample();
      sample_t s;
      int kind, v, a, span;
      bit wide;
      kind = $urandom_range(0, 99);
      wide = (kind >= 85) || ($urandom_range(0, 15) == 0);
      s = make_sample(0, 1, '0, 0, 0, 0,
                      rand_component(wide), rand_component(wide), rand_component(wide),
                      rand_component(wide), rand_component(wide), rand_component(wide));
      if (kind < 80) begin
         v = $urandom_range(0, VIEWERS - 1);
         span = jump_setting * 16;
         case ($urandom_range(0, 7))
            0: a = span;
            1: a = 4 * span + 16;
            default: a = span / 2;
         endcase
         if (a < 1)
            a = 1;
         // hold the frame now and then so the same frame comes twice
         if (kind >= 4)
            walk_frame[v] += $urandom_range(1, 3);
         walk_x[v] += int'($urandom_range(0, 2 * a)) - a;
         walk_y[v] += int'($urandom_range(0, 2 * a)) - a;
         walk_z[v] += int'($urandom_range(0, 2 * a)) - a;
         s.viewer_index = v;
         s.frame_number = walk_frame[v];
         s.pos_x = walk_x[v];
         s.pos_y = walk_y[v];
         s.pos_z = walk_z[v];
      end else begin
         s.viewer_index = $urandom_range(0, 7);
         s.viewer_present = ($urandom_range(0, 3) != 0);
         s.frame_number = $urandom();
         s.pos_x = $urandom();
         s.pos_y = $urandom();
         s.pos_z = $urandom();
      end
      return s;
   endfunction

   task automatic drive_sample(input sample_t s);
      req_viewer_index <= s.viewer_index;
      req_viewer_present <= s.viewer_present;
      req_frame_number <= s.frame_number;
      req_pos_x <= s.pos_x;
      req_pos_y <= s.pos_y;
      req_pos_z <= s.pos_z;
      req_look_x <= s.look_x;
      req_look_y <= s.look_y;
      req_look_z <= s.look_z;
      req_up_x <= s.up_x;
      req_up_y <= s.up_y;
      req_up_z <= s.up_z;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      board.note_sample(s);
   endtask

   task automatic run_random(input int count);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            drive_sample(next_sample());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic write_jump_limit(input logic [JL_W-1:0] value);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_jump_limit <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      board.jump_limit = value;
      jump_setting = value;
   endtask

   initial begin
      int unsigned plan [6];
      for (int i = 0; i < VIEWERS; i++) begin
         walk_frame[i] = '0;
         walk_x[i] = 0;
         walk_y[i] = 0;
         walk_z[i] = 0;
      end
      plan = '{4095, 0, 1, $urandom_range(2, 4094), 200, $urandom_range(2, 4094)};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_sample(make_sample(0, 0, 1, 5, 5, 5, 16384, 0, 0, 0, 16384, 0));
      drive_sample(make_sample(7, 1, 1, 5, 5, 5, 16384, 0, 0, 0, 16384, 0));
      drive_sample(make_sample(4, 1, 1, 5, 5, 5, 16384, 0, 0, 0, 16384, 0));
      drive_sample(make_sample(1, 1, 0, 100, -100, 7, 0, 0, 16384, 0, 16384, 0));
      drive_sample(make_sample(0, 1, 1, 0, 0, 0, 0, 0, 16384, 0, 16384, 0));
      drive_sample(make_sample(0, 1, 2, 3199, 0, 0, 0, 0, 16384, 0, 16384, 0));
      drive_sample(make_sample(0, 1, 3, 6399, 0, 0, 0, 0, 16384, 0, 16384, 0));
      drive_sample(make_sample(0, 1, 3, -900, 40, 40, 0, 0, 16384, 0, 16384, 0));
      drive_sample(make_sample(0, 1, 4, 6000, -1500, 1500, -16384, 0, 0, 0, -16384, 0));
      drive_sample(make_sample(2, 1, 32'hFFFF_FFFF, 524287, 524287, 524287,
                               16384, 16384, 16384, -16384, -16384, -16384));
      drive_sample(make_sample(2, 1, 0, -524288, -524288, -524288,
                               16384, 16384, 16384, -16384, -16384, -16384));
      drive_sample(make_sample(2, 1, 5, -522500, -524000, -523000,
                               16384, -16384, 16384, -16384, 16384, 16384));
      drive_sample(make_sample(2, 0, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_sample(make_sample(3, 1, 1, 1000, 2000, -3000, 0, 16384, 0, 0, 0, 16384));
      drive_sample(make_sample(3, 1, 2, 2800, 400, -1200,
                               -32768, 32767, -32768, 32767, -32768, 32767));
      drive_sample(make_sample(3, 1, 3, 1000, 2000, -3000,
                               32767, 32767, 32767, 32767, 32767, 32767));
      drive_sample(make_sample(3, 1, 4, -800, 3500, -4700,
                               -32768, -32768, -32768, 32767, 32767, 32767));
      drive_sample(make_sample(3, 1, 5, 1000, 2000, -3000,
                               11585, 0, 11585, -11585, 0, 11585));
      drive_sample(make_sample(1, 1, 7, 0, 0, 0, 0, 16384, 0, 16384, 0, 0));
      drive_sample(make_sample(1, 1, 8, -1, -1, -1, 0, 16384, 0, 16384, 0, 0));
      req_valid <= 1'b0;

      foreach (plan[p]) begin
         write_jump_limit(plan[p]);
         run_random(ITEMS_PER_SETTING);
      end

      while (board.pending() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.fails == 0)
         $display("view_relative_motion_phase_top_tb passed");
      else
         $display("view_relative_motion_phase_top_tb failed");
      $finish;
   end

endmodule
